// ----- hdl/lstg_pkg.sv -----
package lstg_pkg;

	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int MAX_CHANNELS = 8;
	localparam int PHASE_BITS = 32;

	localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);
	localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int SINE_W = 16;
	localparam int AMP_W = 16;
	localparam int MCNT_W = $clog2(AMP_W);
	localparam int PROD_W = SINE_W + AMP_W + 1;
	localparam int FMT_W = 50;
	localparam int WORD_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_SAMPLES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDE_SAMPLES = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNED_SAMPLES = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd6;

	localparam logic signed [FMT_W-1:0] ROUND_SIGNED = 50'sd536870912;
	localparam logic signed [FMT_W-1:0] ROUND_OFFSET = 50'sd1073741824;
	localparam logic signed [FMT_W-1:0] ONE_Q30 = 50'sd1073741824;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
		64'd156, 64'd210};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROM,
		ST_MUL,
		ST_FMT,
		ST_SAT
	} state_t;

	typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];

	function automatic logic signed [SINE_W-1:0] sine_q15(logic [31:0] turn);
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic signed [63:0] v;
		r = {34'd0, turn[29:0]};
		if (turn[30]) begin
			r = 64'h4000_0000 - r;
		end
		x = (r * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		term = x;
		sum = signed'(x);
		for (int k = 1; k <= 7; k++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[k];
			if (k[0]) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = (sum + 64'sd16384) >>> 15;
		if (v > 64'sd32767) begin
			v = 64'sd32767;
		end
		if (turn[31]) begin
			v = -v;
		end
		return v[SINE_W-1:0];
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
			rom[i] = sine_q15(32'((64'(i) << 32) / SINE_TABLE_DEPTH));
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ----- hdl/looped_sine_tone_generator_unit.sv -----
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   restart
// out       output     out_valid / out_ready sample_word, last_channel
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A frame passes, from its input beat on, through the phase update, the sine ROM read, the
// bit-serial amplitude multiplier (one amplitude bit per cycle), scaling and saturation; the
// next input beat is taken only after that. The output beats, one per channel, leave an
// output register one per cycle when out_ready is high, as the next frame is computed; a
// finished frame waits in the saturate step until that register is free. The cfg channel is
// always ready. Reset is asynchronous and active low and restores the register defaults.
module looped_sine_tone_generator_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              restart,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lstg_pkg::WORD_W-1:0]       sample_word,
	output logic                              last_channel,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lstg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lstg_pkg::CFG_DATA_W-1:0]   cfg_data
);

	lstg_pkg::state_t st_q;
	lstg_pkg::state_t st_nxt;

	logic [31:0] phase_step_q;
	logic [15:0] loop_samples_q;
	logic [lstg_pkg::AMP_W-1:0] amplitude_q;
	logic wide_q;
	logic signed_q;
	logic big_q;
	logic [3:0] chan_count_q;

	logic [lstg_pkg::PHASE_BITS-1:0] ph_q;
	logic [15:0] cnt_q;
	logic [lstg_pkg::MCNT_W-1:0] mcnt_q;

	logic [lstg_pkg::ADDR_W-1:0] idx_q;
	logic signed [lstg_pkg::PROD_W-1:0] mcand_q;
	logic signed [lstg_pkg::PROD_W-1:0] acc_q;
	logic [lstg_pkg::AMP_W-1:0] amp_q;
	logic signed [lstg_pkg::FMT_W-1:0] t_q;

	logic obusy_q;
	logic [lstg_pkg::CH_W-1:0] och_q;
	logic [lstg_pkg::CH_W-1:0] onch_q;
	logic [lstg_pkg::WORD_W-1:0] oword_q;

	logic in_fire;
	logic out_fire;
	logic handoff;
	logic mul_last;

	logic [lstg_pkg::PHASE_BITS-1:0] ph_eff;
	logic [15:0] cnt_eff;
	logic [16:0] cnt_nxt;
	logic [15:0] loop_eff;
	logic wrap;

	logic signed [lstg_pkg::FMT_W-1:0] v_ext;
	logic signed [lstg_pkg::FMT_W-1:0] t_c;
	logic signed [19:0] w_c;
	logic signed [19:0] m_c;
	logic signed [19:0] lo_c;
	logic signed [19:0] clamp_c;
	logic [lstg_pkg::WORD_W-1:0] word_c;
	logic [lstg_pkg::CH_W-1:0] nch_m1;

	assign cfg_ready = 1'b1;
	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign mul_last = (mcnt_q == lstg_pkg::MCNT_W'(lstg_pkg::AMP_W - 1));

	always_comb begin
		st_nxt = st_q;
		case (st_q)
			lstg_pkg::ST_IDLE: begin
				if (in_valid) begin
					st_nxt = lstg_pkg::ST_ROM;
				end
			end
			lstg_pkg::ST_ROM: st_nxt = lstg_pkg::ST_MUL;
			lstg_pkg::ST_MUL: begin
				if (mul_last) begin
					st_nxt = lstg_pkg::ST_FMT;
				end
			end
			lstg_pkg::ST_FMT: st_nxt = lstg_pkg::ST_SAT;
			lstg_pkg::ST_SAT: begin
				if (!obusy_q) begin
					st_nxt = lstg_pkg::ST_IDLE;
				end
			end
			default: st_nxt = lstg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		handoff = 1'b0;
		case (st_q)
			lstg_pkg::ST_IDLE: in_ready = 1'b1;
			lstg_pkg::ST_SAT: handoff = !obusy_q;
			default: begin
				in_ready = 1'b0;
				handoff = 1'b0;
			end
		endcase
	end

	always_comb begin
		ph_eff = restart ? '0 : ph_q;
		cnt_eff = restart ? '0 : cnt_q;
		cnt_nxt = {1'b0, cnt_eff} + 17'd1;
		loop_eff = (loop_samples_q == 16'd0) ? 16'd1 : loop_samples_q;
		wrap = (cnt_nxt >= {1'b0, loop_eff});
	end

	always_comb begin
		v_ext = {{(lstg_pkg::FMT_W - lstg_pkg::PROD_W){acc_q[lstg_pkg::PROD_W-1]}}, acc_q};
		if (!signed_q) begin
			v_ext = v_ext + lstg_pkg::ONE_Q30;
		end
		case ({signed_q, wide_q})
			2'b11: t_c = (v_ext <<< 15) - v_ext + lstg_pkg::ROUND_SIGNED;
			2'b10: t_c = (v_ext <<< 7) - v_ext + lstg_pkg::ROUND_SIGNED;
			2'b01: t_c = (v_ext <<< 16) - v_ext + lstg_pkg::ROUND_OFFSET;
			2'b00: t_c = (v_ext <<< 8) - v_ext + lstg_pkg::ROUND_OFFSET;
			default: t_c = '0;
		endcase
	end

	always_comb begin
		if (signed_q) begin
			w_c = t_q[49:30];
			m_c = wide_q ? 20'sd32767 : 20'sd127;
			lo_c = -m_c;
		end else begin
			w_c = {t_q[49], t_q[49:31]};
			m_c = wide_q ? 20'sd65535 : 20'sd255;
			lo_c = '0;
		end
		if (w_c > m_c) begin
			clamp_c = m_c;
		end else if (w_c < lo_c) begin
			clamp_c = lo_c;
		end else begin
			clamp_c = w_c;
		end
		if (!wide_q) begin
			word_c = {8'h00, clamp_c[7:0]};
		end else if (big_q) begin
			word_c = {clamp_c[7:0], clamp_c[15:8]};
		end else begin
			word_c = clamp_c[15:0];
		end
		if (chan_count_q == 4'd0) begin
			nch_m1 = '0;
		end else if (chan_count_q > 4'(lstg_pkg::MAX_CHANNELS)) begin
			nch_m1 = lstg_pkg::CH_W'(lstg_pkg::MAX_CHANNELS - 1);
		end else begin
			nch_m1 = lstg_pkg::CH_W'(chan_count_q - 4'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= lstg_pkg::ST_IDLE;
			phase_step_q <= '0;
			loop_samples_q <= 16'd1;
			amplitude_q <= 16'd32768;
			wide_q <= 1'b1;
			signed_q <= 1'b1;
			big_q <= 1'b0;
			chan_count_q <= 4'd1;
			ph_q <= '0;
			cnt_q <= '0;
			mcnt_q <= '0;
			obusy_q <= 1'b0;
			och_q <= '0;
		end else begin
			st_q <= st_nxt;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lstg_pkg::REG_PHASE_STEP: phase_step_q <= cfg_data;
					lstg_pkg::REG_LOOP_SAMPLES: loop_samples_q <= cfg_data[15:0];
					lstg_pkg::REG_AMPLITUDE: amplitude_q <= cfg_data[lstg_pkg::AMP_W-1:0];
					lstg_pkg::REG_WIDE_SAMPLES: wide_q <= cfg_data[0];
					lstg_pkg::REG_SIGNED_SAMPLES: signed_q <= cfg_data[0];
					lstg_pkg::REG_BIG_ENDIAN: big_q <= cfg_data[0];
					lstg_pkg::REG_CHANNEL_COUNT: chan_count_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (in_fire) begin
				if (wrap) begin
					cnt_q <= '0;
					ph_q <= '0;
				end else begin
					cnt_q <= cnt_nxt[15:0];
					ph_q <= ph_eff + phase_step_q[lstg_pkg::PHASE_BITS-1:0];
				end
			end
			if (st_q == lstg_pkg::ST_ROM) begin
				mcnt_q <= '0;
			end else if (st_q == lstg_pkg::ST_MUL) begin
				mcnt_q <= mcnt_q + 1'b1;
			end
			if (handoff) begin
				obusy_q <= 1'b1;
				och_q <= '0;
			end else if (out_fire) begin
				if (och_q == onch_q) begin
					obusy_q <= 1'b0;
				end else begin
					och_q <= och_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			idx_q <= ph_eff[lstg_pkg::PHASE_BITS-1 -: lstg_pkg::ADDR_W];
		end
		case (st_q)
			lstg_pkg::ST_ROM: begin
				mcand_q <= lstg_pkg::PROD_W'(lstg_pkg::SINE_ROM[idx_q]);
				acc_q <= '0;
				amp_q <= amplitude_q;
			end
			lstg_pkg::ST_MUL: begin
				if (amp_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q <= mcand_q <<< 1;
				amp_q <= amp_q >> 1;
			end
			lstg_pkg::ST_FMT: t_q <= t_c;
			default: ;
		endcase
		if (handoff) begin
			oword_q <= word_c;
			onch_q <= nch_m1;
		end
	end

	assign out_valid = obusy_q;
	assign sample_word = oword_q;
	assign last_channel = (och_q == onch_q);

	a_phase_zero_at_loop_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 16'd0) |-> (ph_q == '0))
		else $error("phase not zero at loop start");

	a_handoff_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		handoff |=> (obusy_q && och_q == '0 && st_q == lstg_pkg::ST_IDLE))
		else $error("finished frame not moved to output register");

	a_channel_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		obusy_q |-> (och_q <= onch_q))
		else $error("channel counter past frame end");

	a_mul_runs_full: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == lstg_pkg::ST_MUL && !mul_last) |=> (st_q == lstg_pkg::ST_MUL))
		else $error("multiplier left early");

	a_accept_starts_rom: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (st_q == lstg_pkg::ST_ROM && !in_ready))
		else $error("accepted beat did not start the ROM read");

endmodule

// ----- test/looped_sine_tone_generator_unit_tb.sv -----
`timescale 1ns / 1ps

module looped_sine_tone_generator_unit_tb;

	localparam int ROM_DEPTH = lstg_pkg::SINE_TABLE_DEPTH;
	localparam int CHANNEL_LIMIT = lstg_pkg::MAX_CHANNELS;
	localparam int SETTLE_CYCLES = 30;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int RANDOM_PHASES = 12;
	localparam int ITEMS_PER_PHASE = 40;
	localparam logic [lstg_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [lstg_pkg::WORD_W-1:0] word;
		logic                        last;
	} sample_beat_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic                            restart = 1'b0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [lstg_pkg::WORD_W-1:0]     sample_word;
	logic                            last_channel;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [lstg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [lstg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	looped_sine_tone_generator_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sample_word (sample_word),
		.last_channel(last_channel),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #10 clk = ~clk;

	// Shadow copy of the block's registers and frame state.
	logic [31:0] shadow_step;
	logic [15:0] shadow_loop;
	logic [15:0] shadow_amp;
	logic        shadow_wide;
	logic        shadow_signed;
	logic        shadow_swap;
	logic [3:0]  shadow_channels;
	logic [15:0] shadow_count;
	logic [31:0] shadow_phase;
	logic signed [15:0] sine_rom_copy [ROM_DEPTH];

	bit           tick_queue[$];
	sample_beat_t pending_beats[$];
	sample_beat_t got_beat;

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	bit  send_hold = 1'b0;
	int  hold_req = 0;
	int  hold_ack = 0;
	int  hold_left = 0;
	int  fails = 0;

	function automatic logic signed [15:0] sine_point(logic [31:0] turn);
		longint unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		longint v;
		r = {34'd0, turn[29:0]};
		if (turn[30]) begin
			r = 64'h4000_0000 - r;
		end
		x = (r * 64'd1686629713) >> 30;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int k = 1; k <= 7; k++) begin
			term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = (sum + 64'sd16384) >>> 15;
		if (v > 64'sd32767) begin
			v = 64'sd32767;
		end
		if (turn[31]) begin
			v = -v;
		end
		return v[15:0];
	endfunction

	task automatic synth_frame(bit restart_bit);
		logic [9:0]   addr;
		longint       prod;
		longint       m;
		longint       w;
		logic [15:0]  word;
		int           nch;
		int           loop_len;
		sample_beat_t beat;
		if (restart_bit) begin
			shadow_count = '0;
			shadow_phase = '0;
		end
		addr = shadow_phase[31:22];
		prod = longint'(sine_rom_copy[addr]) * longint'({48'd0, shadow_amp});
		if (shadow_signed) begin
			m = shadow_wide ? 64'sd32767 : 64'sd127;
			w = (prod * m + 64'sd536870912) >>> 30;
			if (w > m) begin
				w = m;
			end
			if (w < -m) begin
				w = -m;
			end
		end else begin
			m = shadow_wide ? 64'sd65535 : 64'sd255;
			w = ((64'sd1073741824 + prod) * m + 64'sd1073741824) >>> 31;
			if (w > m) begin
				w = m;
			end
			if (w < 0) begin
				w = 0;
			end
		end
		if (!shadow_wide) begin
			word = {8'd0, w[7:0]};
		end else if (shadow_swap) begin
			word = {w[7:0], w[15:8]};
		end else begin
			word = w[15:0];
		end
		nch = int'(shadow_channels);
		if (nch == 0) begin
			nch = 1;
		end
		if (nch > CHANNEL_LIMIT) begin
			nch = CHANNEL_LIMIT;
		end
		for (int c = 0; c < nch; c++) begin
			beat.word = word;
			beat.last = (c == nch - 1);
			pending_beats.push_back(beat);
		end
		loop_len = (shadow_loop == 0) ? 1 : int'(shadow_loop);
		if (int'(shadow_count) + 1 >= loop_len) begin
			shadow_count = '0;
			shadow_phase = '0;
		end else begin
			shadow_count = shadow_count + 16'd1;
			shadow_phase = shadow_phase + shadow_step;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			restart <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				synth_frame(restart);
			end
			if (!in_valid || in_ready) begin
				if (tick_queue.size() != 0 && !send_hold &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					restart <= tick_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_beats.size() == 0) begin
					$error("unexpected beat: sample_word=%h last_channel=%b",
						sample_word, last_channel);
					fails++;
				end else begin
					got_beat = pending_beats.pop_front();
					if (sample_word !== got_beat.word) begin
						$error("sample_word: expected %h, actual %h", got_beat.word, sample_word);
						fails++;
					end
					if (last_channel !== got_beat.last) begin
						$error("last_channel: expected %b, actual %b", got_beat.last,
							last_channel);
						fails++;
					end
				end
			end
			if (hold_ack != hold_req) begin
				hold_ack <= hold_req;
				hold_left <= LONG_HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	task automatic write_reg(logic [lstg_pkg::CFG_IDX_W-1:0] idx,
			logic [lstg_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		case (idx)
			lstg_pkg::REG_PHASE_STEP: shadow_step = value;
			lstg_pkg::REG_LOOP_SAMPLES: shadow_loop = value[15:0];
			lstg_pkg::REG_AMPLITUDE: shadow_amp = value[15:0];
			lstg_pkg::REG_WIDE_SAMPLES: shadow_wide = value[0];
			lstg_pkg::REG_SIGNED_SAMPLES: shadow_signed = value[0];
			lstg_pkg::REG_BIG_ENDIAN: shadow_swap = value[0];
			lstg_pkg::REG_CHANNEL_COUNT: shadow_channels = value[3:0];
			default: ;
		endcase
	endtask

	task automatic set_tone(logic [31:0] step, logic [31:0] loop_len, logic [31:0] amp,
			logic [31:0] wide, logic [31:0] sgn, logic [31:0] swap, logic [31:0] chans);
		write_reg(lstg_pkg::REG_PHASE_STEP, step);
		write_reg(lstg_pkg::REG_LOOP_SAMPLES, loop_len);
		write_reg(lstg_pkg::REG_AMPLITUDE, amp);
		write_reg(lstg_pkg::REG_WIDE_SAMPLES, wide);
		write_reg(lstg_pkg::REG_SIGNED_SAMPLES, sgn);
		write_reg(lstg_pkg::REG_BIG_ENDIAN, swap);
		write_reg(lstg_pkg::REG_CHANNEL_COUNT, chans);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (tick_queue.size() != 0 || in_valid || pending_beats.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [31:0] r_step;
		logic [31:0] r_loop;
		logic [31:0] r_amp;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			sine_rom_copy[i] = sine_point(32'((64'(i) << 32) / ROM_DEPTH));
		end
		shadow_step = '0;
		shadow_loop = 16'd1;
		shadow_amp = 16'd32768;
		shadow_wide = 1'b1;
		shadow_signed = 1'b1;
		shadow_swap = 1'b0;
		shadow_channels = 4'd1;
		shadow_count = '0;
		shadow_phase = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(negedge clk);

		// Register defaults straight out of reset.
		tick_queue.push_back(1'b0);
		tick_queue.push_back(1'b1);
		wait_drained();

		// Quarter-turn steps over a loop of four, full scale, all eight channels.
		set_tone(32'h4000_0000, 32'd4, 32'd32768, 32'd1, 32'd1, 32'd0, 32'd8);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		repeat (6) tick_queue.push_back(1'b0);
		wait_drained();

		// Amplitude past full scale, offset binary, swapped bytes, channel count above the limit.
		set_tone(32'h4000_0000, 32'd4, 32'd65535, 32'd1, 32'd0, 32'd1, 32'd9);
		tick_queue.push_back(1'b0);
		tick_queue.push_back(1'b0);
		tick_queue.push_back(1'b1);
		tick_queue.push_back(1'b0);
		tick_queue.push_back(1'b0);
		tick_queue.push_back(1'b0);
		wait_drained();

		// Narrow signed samples, byte swap requested, zero loop length and zero channels.
		set_tone(32'hFFFF_FFFF, 32'd0, 32'd65535, 32'd0, 32'd1, 32'd1, 32'd0);
		repeat (3) tick_queue.push_back(1'b0);
		wait_drained();

		// Narrow offset binary at zero gain, longest loop, widest channel field.
		set_tone(32'h2000_0000, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd15);
		repeat (3) tick_queue.push_back(1'b0);
		wait_drained();
		write_reg(lstg_pkg::REG_AMPLITUDE, 32'd32768);
		repeat (2) tick_queue.push_back(1'b0);
		wait_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p < RANDOM_PHASES / 3) begin
				send_idle_pct = 24;
				recv_idle_pct = 80;
			end else if (p < 2 * RANDOM_PHASES / 3) begin
				send_idle_pct = 80;
				recv_idle_pct = 24;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case ($urandom_range(0, 4))
				0: r_step = 32'd0;
				1: r_step = 32'hFFFF_FFFF;
				2: r_step = 32'h4000_0000 >> $urandom_range(0, 12);
				default: r_step = $urandom;
			endcase
			case ($urandom_range(0, 5))
				0: r_loop = 32'd0;
				1: r_loop = 32'hFFFF;
				2: r_loop = 32'd1;
				default: r_loop = $urandom_range(2, 24);
			endcase
			case ($urandom_range(0, 4))
				0: r_amp = 32'd0;
				1: r_amp = 32'd32768;
				2: r_amp = 32'd65535;
				default: r_amp = $urandom_range(0, 65535);
			endcase
			set_tone(r_step, r_loop, r_amp, $urandom_range(0, 1), $urandom_range(0, 1),
				$urandom_range(0, 1), $urandom_range(0, 15));
			if ($urandom_range(0, 3) == 0) begin
				write_reg(REG_UNUSED, $urandom);
			end
			if (p == RANDOM_PHASES / 2) begin
				for (int i = 0; i < ITEMS_PER_PHASE / 2; i++) begin
					tick_queue.push_back($urandom_range(0, 9) == 0);
				end
				while (tick_queue.size() != 0) begin
					@(negedge clk);
				end
				send_hold = 1'b1;
				for (int i = 0; i < ITEMS_PER_PHASE / 2; i++) begin
					tick_queue.push_back($urandom_range(0, 9) == 0);
				end
				while (in_valid || pending_beats.size() != 0) begin
					@(negedge clk);
				end
				repeat ($urandom_range(1, 20)) @(negedge clk);
				send_hold = 1'b0;
			end else begin
				for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
					tick_queue.push_back($urandom_range(0, 9) == 0);
				end
				if (p == RANDOM_PHASES - 3 || p == 1) begin
					hold_req = hold_req + 1;
				end
			end
			wait_drained();
		end

		if (fails == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/lstg_pkg.sv
hdl/looped_sine_tone_generator_unit.sv
test/looped_sine_tone_generator_unit_tb.sv
